>>> rtl/dspi_pkg.sv
// Shared types and constants for the disk set prune and inclusion block.
package dspi_pkg;

  // Default table depth
  localparam int MAX_DISKS_DEF = 64;

  // Coordinate and radius width, and the widths of differences, squares and sums
  localparam int CoordW = 32;
  localparam int DiffW  = CoordW + 1;
  localparam int SqW    = 2 * DiffW;
  localparam int SumW   = SqW + 1;

  // One stored disk, as held in the table memory
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic        [CoordW-1:0] r;
  } disk_t;

  // Squared terms of one table entry against the query disk
  typedef struct packed {
    logic [SqW-1:0]      dx2;
    logic [SqW-1:0]      dy2;
    logic [SqW-1:0]      rs2;
    logic [2*CoordW-1:0] rd2;
    logic                rd_ok;
  } prod_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  // Control strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic walk_done;
    logic out_load;
  } ctrl_t;

endpackage

>>> rtl/dspi_ram.sv
// Generic single write port, single read port RAM with registered read data.
module dspi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/dspi_dist.sv
// Two-stage pipeline forming the squared distance and radius terms of one entry.
module dspi_dist (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  dspi_pkg::disk_t entry_i,
  input  dspi_pkg::disk_t query_i,
  output logic            mid_valid_o,
  output logic            valid_o,
  output dspi_pkg::disk_t entry_o,
  output dspi_pkg::prod_t prod_o
);

  localparam int DW = dspi_pkg::DiffW;
  localparam int SW = dspi_pkg::SqW;
  localparam int CW = dspi_pkg::CoordW;

  logic signed [DW-1:0] dx_s, dy_s;
  logic [DW-1:0]        dx_d, dy_d, rs_d, rd_full;
  logic [DW-1:0]        dx_q, dy_q, rs_q;
  logic [CW-1:0]        rd_q;
  logic                 rd_ok_q;
  logic                 va_q, vb_q;
  dspi_pkg::disk_t      ea_q, eb_q;
  dspi_pkg::prod_t      prod_d, prod_q;

  // Stage A: absolute differences, radius sum and difference
  always_comb begin
    dx_s    = $signed({query_i.x[CW-1], query_i.x}) - $signed({entry_i.x[CW-1], entry_i.x});
    dy_s    = $signed({query_i.y[CW-1], query_i.y}) - $signed({entry_i.y[CW-1], entry_i.y});
    dx_d    = dx_s[DW-1] ? DW'(-dx_s) : DW'(dx_s);
    dy_d    = dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s);
    rs_d    = {1'b0, entry_i.r} + {1'b0, query_i.r};
    rd_full = {1'b0, entry_i.r} - {1'b0, query_i.r};
  end

  // Stage B: squares
  always_comb begin
    prod_d.dx2   = SW'(dx_q) * SW'(dx_q);
    prod_d.dy2   = SW'(dy_q) * SW'(dy_q);
    prod_d.rs2   = SW'(rs_q) * SW'(rs_q);
    prod_d.rd2   = (2*CW)'(rd_q) * (2*CW)'(rd_q);
    prod_d.rd_ok = rd_ok_q;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  // Hold payload of both stages
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      rs_q    <= rs_d;
      rd_q    <= rd_full[CW-1:0];
      rd_ok_q <= ~rd_full[DW-1];
      ea_q    <= entry_i;
    end
    if (va_q) begin
      prod_q <= prod_d;
      eb_q   <= ea_q;
    end
  end

  assign mid_valid_o = va_q;
  assign valid_o     = vb_q;
  assign entry_o     = eb_q;
  assign prod_o      = prod_q;

endmodule

>>> rtl/disk_set_prune_and_inclusion.sv
// Top level: disk table sequencer, compaction write-back and result register.
//
// Keeps up to MAX_DISKS disks in one table RAM and a sticky empty flag. A load
// transaction writes the table, then loads the result. An update transaction
// walks the N stored disks, or goes straight to the result when the table is
// empty: the walk reads one entry per cycle through the single RAM read port, a
// pipeline of read, differences and squares stages follows, and the sum and
// compares then decide whether the entry is written back to the next kept slot.
// The kept slot never passes the read pointer, so write-back never overtakes a
// pending read. A new transaction is taken while the previous result waits on
// the output.
module disk_set_prune_and_inclusion #(
  parameter int MAX_DISKS = dspi_pkg::MAX_DISKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic        clear_first_i,
  input  logic [31:0] center_x_i,
  input  logic [31:0] center_y_i,
  input  logic [31:0] radius_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_empty_o,
  output logic [6:0]  disks_kept_o,
  output logic        table_full_o
);

  localparam int AW  = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
  localparam int CW  = $clog2(MAX_DISKS + 1);
  localparam int SUW = dspi_pkg::SumW;

  dspi_pkg::state_e state_q, state_d;
  dspi_pkg::ctrl_t  ctrl;

  logic            in_acc, is_load, load_full;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   wr_ptr_q, wr_ptr_d;
  logic            flag_q, flag_d;
  logic            res_full_q, res_full_d;
  dspi_pkg::disk_t query_q, in_disk;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr;
  dspi_pkg::disk_t ram_wdata, ram_rdata;
  logic            v1_q;

  logic            pmid;
  logic            pv;
  dspi_pkg::disk_t pentry;
  dspi_pkg::prod_t prod;
  logic [SUW-1:0]  d2;
  logic            keep, hit;

  logic            out_valid_q, out_valid_d;
  logic            out_empty_q, out_full_q;
  logic [6:0]      out_kept_q;
  logic [CW+6:0]   count_ext;

  assign in_stall_o = (state_q != dspi_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_load    = !cmd_i;
  assign load_full  = !clear_first_i && (count_q == CW'(MAX_DISKS));
  assign in_disk    = '{x: center_x_i, y: center_y_i, r: radius_i};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dspi_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (is_load || count_q == '0) ? dspi_pkg::ST_FINISH : dspi_pkg::ST_WALK;
        end
      end
      dspi_pkg::ST_WALK: begin
        if (ctrl.walk_done) state_d = dspi_pkg::ST_FINISH;
      end
      dspi_pkg::ST_FINISH: begin
        if (ctrl.out_load) state_d = dspi_pkg::ST_IDLE;
      end
      default: state_d = dspi_pkg::ST_IDLE;
    endcase
  end

  // Sequencer strobes
  always_comb begin
    ctrl = '0;
    case (state_q)
      dspi_pkg::ST_WALK: begin
        ctrl.rd_en     = (rd_ptr_q < count_q);
        ctrl.walk_done = !(rd_ptr_q < count_q) && !v1_q && !pmid && !pv;
      end
      dspi_pkg::ST_FINISH: begin
        ctrl.out_load = !out_valid_q || !out_stall_i;
      end
      default: ctrl = '0;
    endcase
  end

  // Sum of squares and keep / inclusion decision for the entry leaving the pipeline
  always_comb begin
    d2   = SUW'(prod.dx2) + SUW'(prod.dy2);
    keep = d2 < SUW'(prod.rs2);
    hit  = keep && prod.rd_ok && (d2 <= SUW'(prod.rd2));
  end

  // Table write: append on load (slot 0 when clearing first), compact on update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_ptr_q[AW-1:0];
    ram_wdata = pentry;
    if (in_acc && is_load && !load_full) begin
      ram_we    = 1'b1;
      ram_waddr = clear_first_i ? '0 : count_q[AW-1:0];
      ram_wdata = in_disk;
    end else if (pv && keep) begin
      ram_we = 1'b1;
    end
    ram_re = ctrl.rd_en;
  end

  // Next values of table control state
  always_comb begin
    count_d    = count_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    flag_d     = flag_q;
    res_full_d = res_full_q;
    if (in_acc) begin
      rd_ptr_d   = '0;
      wr_ptr_d   = '0;
      res_full_d = is_load && load_full;
      if (is_load) begin
        if (clear_first_i) begin
          count_d = CW'(1);
          flag_d  = 1'b0;
        end else if (!load_full) begin
          count_d = count_q + CW'(1);
        end
      end
    end
    if (ctrl.rd_en) rd_ptr_d = rd_ptr_q + CW'(1);
    if (pv && keep) wr_ptr_d = wr_ptr_q + CW'(1);
    if (pv && hit) flag_d = 1'b1;
    if (ctrl.walk_done) count_d = wr_ptr_q;
  end

  // Drop the result once taken, load it when the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (ctrl.out_load) out_valid_d = 1'b1;
  end

  assign count_ext = {7'b0, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dspi_pkg::ST_IDLE;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      flag_q      <= 1'b1;
      res_full_q  <= 1'b0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      flag_q      <= flag_d;
      res_full_q  <= res_full_d;
      v1_q        <= ctrl.rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold query and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) query_q <= in_disk;
    if (ctrl.out_load) begin
      out_empty_q <= flag_q;
      out_kept_q  <= count_ext[6:0];
      out_full_q  <= res_full_q;
    end
  end

  dspi_ram #(
    .WIDTH ($bits(dspi_pkg::disk_t)),
    .DEPTH (MAX_DISKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  dspi_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v1_q),
    .entry_i     (ram_rdata),
    .query_i     (query_q),
    .mid_valid_o (pmid),
    .valid_o     (pv),
    .entry_o     (pentry),
    .prod_o      (prod)
  );

  assign out_valid_o  = out_valid_q;
  assign is_empty_o   = out_empty_q;
  assign disks_kept_o = out_kept_q;
  assign table_full_o = out_full_q;

  // Kept slot never runs ahead of the read pointer
  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ptr_q <= rd_ptr_q) else $error("kept slot ahead of read pointer");

  // Compaction writes land strictly below the next entry to be read
  a_wb_below_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pv && keep) |-> (wr_ptr_q < rd_ptr_q)) else $error("write-back overtakes read");

  // Walk pipeline is busy only while walking
  a_pipe_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q || pmid || pv) |-> (state_q == dspi_pkg::ST_WALK))
    else $error("pipeline busy outside walk");

  // Table count stays within its depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_DISKS)) else $error("disk count beyond table depth");

endmodule
